@@ rtl/core/smvr_pkg.sv @@
// ----------------------------------------------------------------------------
// smvr_pkg
// Shared widths, codes, stage records and saturating arithmetic for the
// CSR sparse matrix-vector row engine.
// ----------------------------------------------------------------------------
package smvr_pkg;

    localparam int SMVR_VECTOR_DEPTH = 1024;
    localparam int FIFO_DEPTH        = 8;

    localparam int KIND_W   = 2;
    localparam int POS_W    = 11;
    localparam int DATA_W   = 32;
    localparam int SUM_W    = 64;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NONZERO = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ROW_END = 2'd2;

    localparam logic REG_INDEX_BASE = 1'b0;

    typedef struct packed {
        logic                     valid;
        logic                     use_prod;
        logic                     col_bad;
        logic                     ends_row;
        logic signed [DATA_W-1:0] data;
        logic signed [SUM_W-1:0]  prior;
    } t_s1;

    typedef struct packed {
        logic                    valid;
        logic                    use_prod;
        logic                    col_bad;
        logic                    ends_row;
        logic signed [SUM_W-1:0] prod;
        logic signed [SUM_W-1:0] prior;
    } t_s2;

    typedef struct packed {
        logic                    valid;
        logic                    err;
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] prior;
    } t_s3;

    typedef struct packed {
        logic signed [SUM_W-1:0] row_sum;
        logic                    column_error;
    } t_result;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic signed [SUM_W:0]   s;
        logic signed [SUM_W-1:0] r;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1]) begin
            r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            r = s[SUM_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/smvr_if.sv @@
// ----------------------------------------------------------------------------
// smvr_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface smvr_in_if import smvr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] data;
    logic                     last_in_row;
    logic signed [SUM_W-1:0]  prior_sum;

    modport source(output valid, kind, position, data, last_in_row, prior_sum, input ready);
    modport sink(input valid, kind, position, data, last_in_row, prior_sum, output ready);
endinterface

interface smvr_out_if import smvr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] row_sum;
    logic                    column_error;

    modport source(output valid, row_sum, column_error, input ready);
    modport sink(input valid, row_sum, column_error, output ready);
endinterface

@@ rtl/core/sparse_matrix_vector_rows_top.sv @@
// ----------------------------------------------------------------------------
// sparse_matrix_vector_rows_top
// A row-ending word passes r_s1 with the vector-store read, r_s2, r_s3 and
// the result queue. Throughput: one input word per cycle when a queue slot is
// free, set by the accumulate loop after the registered read and the multiply.
// Reset clears index_base, the row accumulator, the error flag and the result
// queue; the vector store is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
module sparse_matrix_vector_rows_top import smvr_pkg::*; #(
    parameter int VECTOR_DEPTH = SMVR_VECTOR_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    smvr_in_if.sink           i_item,
    smvr_out_if.source        o_result
);

    localparam int AW = $clog2(VECTOR_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic                     r_index_base;
    logic [CW-1:0]            r_used;
    t_s1                      r_s1;
    t_s1                      n_s1;
    logic                     accept;
    logic                     produces;
    logic                     pop;
    logic [POS_W:0]           col_w;
    logic [31:0]              col_x;
    logic [31:0]              pos_x;
    logic                     col_ok;
    logic                     pos_ok;
    logic                     wr_en;
    logic signed [DATA_W-1:0] x_data;
    logic                     res_valid;
    t_result                  res_word;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_INDEX_BASE) ? {{(APB_DW-1){1'b0}}, r_index_base} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_base <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_INDEX_BASE) begin
            r_index_base <= pwdata[0];
        end
    end

    // Decode
    assign accept = i_item.valid && i_item.ready;
    assign col_w  = {1'b0, i_item.position} - {{POS_W{1'b0}}, r_index_base};
    assign col_x  = {{(32-POS_W-1){1'b0}}, col_w};
    assign pos_x  = {{(32-POS_W){1'b0}}, i_item.position};
    assign col_ok = (i_item.position >= {{(POS_W-1){1'b0}}, r_index_base})
                    && (col_x < 32'(VECTOR_DEPTH));
    assign pos_ok = pos_x < 32'(VECTOR_DEPTH);

    always_comb begin
        n_s1          = '0;
        n_s1.data     = i_item.data;
        n_s1.prior    = i_item.prior_sum;
        wr_en         = 1'b0;
        produces      = 1'b0;
        unique case (i_item.kind)
            KIND_LOAD: begin
                wr_en = accept && pos_ok;
            end
            KIND_NONZERO: begin
                n_s1.valid    = accept;
                n_s1.use_prod = col_ok;
                n_s1.col_bad  = !col_ok;
                n_s1.ends_row = i_item.last_in_row;
                produces      = i_item.last_in_row;
            end
            KIND_ROW_END: begin
                n_s1.valid    = accept;
                n_s1.ends_row = 1'b1;
                produces      = 1'b1;
            end
            default: begin
                n_s1.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_s1.use_prod <= n_s1.use_prod;
        r_s1.col_bad  <= n_s1.col_bad;
        r_s1.ends_row <= n_s1.ends_row;
        r_s1.data     <= n_s1.data;
        r_s1.prior    <= n_s1.prior;
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_used     <= '0;
        end else begin
            r_s1.valid <= n_s1.valid;
            r_used     <= r_used + CW'(accept && produces) - CW'(pop);
        end
    end

    // Hold off input once queue slots are all spoken for
    assign i_item.ready = (r_used < CW'(FIFO_DEPTH));

    smvr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (VECTOR_DEPTH)
    ) u_vector_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (pos_x[AW-1:0]),
        .i_wr_data (i_item.data),
        .i_rd_en   (accept),
        .i_rd_addr (col_x[AW-1:0]),
        .o_rd_data (x_data)
    );

    smvr_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1        (r_s1),
        .i_x         (x_data),
        .o_res_valid (res_valid),
        .o_res       (res_word)
    );

    smvr_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (res_valid),
        .i_word   (res_word),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

@@ rtl/core/smvr_ram.sv @@
// ----------------------------------------------------------------------------
// smvr_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module smvr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/smvr_mac.sv @@
// ----------------------------------------------------------------------------
// smvr_mac
// Multiply, saturating row accumulate and final prior-sum add.
// ----------------------------------------------------------------------------
module smvr_mac import smvr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_s1                      i_s1,
    input  logic signed [DATA_W-1:0] i_x,
    output logic                     o_res_valid,
    output t_result                  o_res
);

    t_s2                     r_s2;
    t_s3                     r_s3;
    logic signed [SUM_W-1:0] r_acc;
    logic                    r_err;
    logic signed [SUM_W-1:0] n_acc;
    logic                    n_err;

    always_comb begin
        n_acc = r_acc;
        n_err = r_err;
        if (r_s2.valid && r_s2.use_prod) begin
            n_acc = sat_add(r_acc, r_s2.prod);
        end
        if (r_s2.valid && r_s2.col_bad) begin
            n_err = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
            r_acc      <= '0;
            r_err      <= 1'b0;
        end else begin
            r_s2.valid    <= i_s1.valid;
            r_s2.use_prod <= i_s1.use_prod;
            r_s2.col_bad  <= i_s1.col_bad;
            r_s2.ends_row <= i_s1.ends_row;
            r_s2.prod     <= SUM_W'(i_s1.data) * SUM_W'(i_x);
            r_s2.prior    <= i_s1.prior;

            r_s3.valid <= r_s2.valid && r_s2.ends_row;
            r_s3.acc   <= n_acc;
            r_s3.err   <= n_err;
            r_s3.prior <= r_s2.prior;
            if (r_s2.valid && r_s2.ends_row) begin
                r_acc <= '0;
                r_err <= 1'b0;
            end else begin
                r_acc <= n_acc;
                r_err <= n_err;
            end
        end
    end

    assign o_res_valid         = r_s3.valid;
    assign o_res.row_sum       = sat_add(r_s3.prior, r_s3.acc);
    assign o_res.column_error  = r_s3.err;

endmodule

@@ rtl/core/smvr_out_fifo.sv @@
// ----------------------------------------------------------------------------
// smvr_out_fifo
// Result queue that absorbs the words in flight while the sink stalls.
// ----------------------------------------------------------------------------
module smvr_out_fifo import smvr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_result   i_word,
    output logic      o_pop,
    smvr_out_if.source o_result
);

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_result         r_mem [FIFO_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            pop;

    assign pop   = o_result.valid && o_result.ready;
    assign o_pop = pop;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= r_count + CW'(i_push) - CW'(pop);
        end
    end

    assign o_result.valid        = (r_count != '0);
    assign o_result.row_sum      = r_mem[r_rd_ptr].row_sum;
    assign o_result.column_error = r_mem[r_rd_ptr].column_error;

endmodule
